// ===== rtl/cle_pkg.sv =====
package cle_pkg;

    // line store size and ring position arithmetic
    localparam int BUF_DEPTH = 128;
    localparam int POS_MOD   = 2 * BUF_DEPTH;
    localparam int SLOT_W    = $clog2(BUF_DEPTH);
    localparam int POS_W     = $clog2(POS_MOD);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [7:0]        char_t;

    localparam pos_t POS_LAST  = pos_t'(POS_MOD - 1);
    localparam pos_t DEPTH_POS = pos_t'(BUF_DEPTH);
    localparam pos_t DEPTH_M1  = pos_t'(BUF_DEPTH - 1);
    localparam pos_t POS_WRAP  = pos_t'(POS_MOD);

    // control keys
    localparam char_t KEY_NUL  = 8'h00;
    localparam char_t KEY_EOF  = 8'h04;
    localparam char_t KEY_BS   = 8'h08;
    localparam char_t KEY_LF   = 8'h0a;
    localparam char_t KEY_CR   = 8'h0d;
    localparam char_t KEY_KILL = 8'h15;
    localparam char_t KEY_DEL  = 8'h7f;

    localparam char_t ERASE_MAX = 8'hff;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        ECHO_NONE  = 2'd0,
        ECHO_CHAR  = 2'd1,
        ECHO_ERASE = 2'd2
    } echo_kind_t;

    typedef enum logic [2:0] {
        RD_NONE      = 3'd0,
        RD_BYTE      = 3'd1,
        RD_EMPTY     = 3'd2,
        RD_EOF_TAKEN = 3'd3,
        RD_EOF_KEPT  = 3'd4
    } read_status_t;

    typedef struct packed {
        echo_kind_t   echo_kind;
        char_t        echo_char;
        char_t        erase_count;
        logic         line_ready;
        read_status_t read_status;
        char_t        read_char;
    } result_t;

    function automatic pos_t pos_next(input pos_t p);
        return (p == POS_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic pos_t pos_prev(input pos_t p);
        return (p == '0) ? POS_LAST : p - 1'b1;
    endfunction

    function automatic pos_t pos_dist(input pos_t later, input pos_t earlier);
        pos_t diff;
        diff = later - earlier;
        return (later < earlier) ? diff + POS_WRAP : diff;
    endfunction

    function automatic slot_t pos_slot(input pos_t p);
        return (p >= DEPTH_POS) ? slot_t'(p - DEPTH_POS) : slot_t'(p);
    endfunction

    function automatic char_t erase_sat(input pos_t n);
        return (int'(n) > 255) ? ERASE_MAX : char_t'(n);
    endfunction

endpackage

// ===== rtl/cle_in_if.sv =====
interface cle_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_char;
    logic       read_started;

    modport source (output valid, output operation, output rx_char, output read_started,
                     input ready);
    modport sink (input valid, input operation, input rx_char, input read_started,
                  output ready);
endinterface

// ===== rtl/cle_out_if.sv =====
interface cle_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] echo_kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_ready;
    logic [2:0] read_status;
    logic [7:0] read_char;

    modport source (output valid, output echo_kind, output echo_char, output erase_count,
                     output line_ready, output read_status, output read_char,
                     input ready);
    modport sink (input valid, input echo_kind, input echo_char, input erase_count,
                  input line_ready, input read_status, input read_char,
                  output ready);
endinterface

// ===== rtl/cle_ram.sv =====
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/cle_ctrl.sv =====
module cle_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             operation,
    input  logic [7:0]       rx_char,
    input  logic             read_started,
    output cle_pkg::result_t result
);

    cle_pkg::pos_t  read_reg, read_next;
    cle_pkg::pos_t  commit_reg, commit_next;
    cle_pkg::pos_t  edit_reg, edit_next;
    logic           fwd_hit_reg, fwd_hit_next;
    cle_pkg::char_t fwd_data_reg;

    logic           we;
    cle_pkg::slot_t waddr, raddr;
    cle_pkg::char_t wdata, ram_rdata, head;
    cle_pkg::char_t ch;
    cle_pkg::pos_t  used, typed;

    // head byte at the read position, with bypass of a write to the same slot during the fetch
    assign head = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        read_next   = read_reg;
        commit_next = commit_reg;
        edit_next   = edit_reg;
        we          = 1'b0;
        wdata       = rx_char;
        waddr       = cle_pkg::pos_slot(edit_reg);
        used        = cle_pkg::pos_dist(edit_reg, read_reg);
        typed       = cle_pkg::pos_dist(edit_reg, commit_reg);
        ch          = (rx_char == cle_pkg::KEY_CR) ? cle_pkg::KEY_LF : rx_char;
        result      = '0;

        if (operation == cle_pkg::OP_RX)
        begin
            if (rx_char == cle_pkg::KEY_KILL)
            begin
                if (typed != '0)
                begin
                    edit_next          = commit_reg;
                    result.echo_kind   = cle_pkg::ECHO_ERASE;
                    result.erase_count = cle_pkg::erase_sat(typed);
                end
            end
            else if (rx_char == cle_pkg::KEY_BS || rx_char == cle_pkg::KEY_DEL)
            begin
                if (edit_reg != commit_reg)
                begin
                    edit_next          = cle_pkg::pos_prev(edit_reg);
                    result.echo_kind   = cle_pkg::ECHO_ERASE;
                    result.erase_count = 8'd1;
                end
            end
            else if (rx_char != cle_pkg::KEY_NUL && used < cle_pkg::DEPTH_POS)
            begin
                we               = fire;
                wdata            = ch;
                edit_next        = cle_pkg::pos_next(edit_reg);
                result.echo_kind = cle_pkg::ECHO_CHAR;
                result.echo_char = ch;
                // commit on newline, end of file or when the store fills up
                if (ch == cle_pkg::KEY_LF || ch == cle_pkg::KEY_EOF ||
                    used == cle_pkg::DEPTH_M1)
                begin
                    commit_next       = cle_pkg::pos_next(edit_reg);
                    result.line_ready = 1'b1;
                end
            end
        end
        else
        begin
            if (read_reg == commit_reg)
            begin
                result.read_status = cle_pkg::RD_EMPTY;
            end
            else if (head == cle_pkg::KEY_EOF)
            begin
                if (read_started)
                begin
                    result.read_status = cle_pkg::RD_EOF_KEPT;
                end
                else
                begin
                    read_next          = cle_pkg::pos_next(read_reg);
                    result.read_status = cle_pkg::RD_EOF_TAKEN;
                end
            end
            else
            begin
                read_next          = cle_pkg::pos_next(read_reg);
                result.read_status = cle_pkg::RD_BYTE;
                result.read_char   = head;
            end
        end

        if (!fire)
        begin
            read_next   = read_reg;
            commit_next = commit_reg;
            edit_next   = edit_reg;
        end

        raddr        = cle_pkg::pos_slot(read_next);
        fwd_hit_next = we && (waddr == raddr);
    end

    cle_ram #(
        .WIDTH(8),
        .DEPTH(cle_pkg::BUF_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_reg    <= '0;
            commit_reg  <= '0;
            edit_reg    <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            read_reg    <= read_next;
            commit_reg  <= commit_next;
            edit_reg    <= edit_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wdata;
    end

endmodule

// ===== rtl/console_line_editor_top.sv =====
// console line editor: canonical line buffer for a serial console
//
// req carries one beat per item: operation 0 hands in a received byte
// (rx_char), operation 1 asks for one committed byte (read_started tells
// whether the current read request already returned bytes)
// rsp returns exactly one beat per req beat, in order: echo or erase
// information for received bytes, read_status and read_char for reads
//
// the result beat is registered and valid the cycle after the req beat is taken
// one item per cycle while the receiver keeps up; the line store is a
// single-port-write, registered-read memory, and the byte at the read
// position is fetched every cycle so a read item never waits on the memory
//
// reset clears the read, commit and edit positions (store is empty); the
// store contents are not cleared and no clearing pass is needed
// when the receiver stalls, the result beat holds in the output register
// and req.ready drops until it is taken
module console_line_editor_top (
    input  logic      clk,
    input  logic      rst_n,
    cle_in_if.sink    req,
    cle_out_if.source rsp
);

    logic              fire;
    logic              out_valid_reg, out_valid_next;
    cle_pkg::result_t  result;
    cle_pkg::result_t  out_data_reg;

    // output register frees up as the receiver takes the pending beat
    assign req.ready = !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    // line store, positions and per-item decode
    cle_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .operation    (req.operation),
        .rx_char      (req.rx_char),
        .read_started (req.read_started),
        .result       (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a beat is taken
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.echo_kind   = out_data_reg.echo_kind;
    assign rsp.echo_char   = out_data_reg.echo_char;
    assign rsp.erase_count = out_data_reg.erase_count;
    assign rsp.line_ready  = out_data_reg.line_ready;
    assign rsp.read_status = out_data_reg.read_status;
    assign rsp.read_char   = out_data_reg.read_char;

endmodule

// ===== rtl/cle_checker.sv =====
module cle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] echo_kind,
    input logic [7:0] echo_char,
    input logic [7:0] erase_count,
    input logic       line_ready,
    input logic [2:0] read_status,
    input logic [7:0] read_char
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(echo_kind) &&
        $stable(echo_char) && $stable(erase_count) && $stable(line_ready) &&
        $stable(read_status) && $stable(read_char))
        else $error("stalled result beat changed");

    // every taken item gives a result beat on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("missing result beat");

    // a read result carries no echo and no commit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_status != cle_pkg::RD_NONE |->
        echo_kind == cle_pkg::ECHO_NONE && !line_ready)
        else $error("read result with echo");

    // a commit only follows a stored and echoed byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_ready |-> echo_kind == cle_pkg::ECHO_CHAR && echo_char != 8'd0)
        else $error("commit without stored byte");

    // erase counts are nonzero, other fields idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && echo_kind == cle_pkg::ECHO_ERASE |->
        erase_count != 8'd0 && echo_char == 8'd0 && read_char == 8'd0)
        else $error("bad erase result");

endmodule

bind console_line_editor_top cle_checker u_cle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .echo_kind   (rsp.echo_kind),
    .echo_char   (rsp.echo_char),
    .erase_count (rsp.erase_count),
    .line_ready  (rsp.line_ready),
    .read_status (rsp.read_status),
    .read_char   (rsp.read_char)
);

// ===== tb/sv/cle_line_checker.sv =====
module cle_line_checker
    import cle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cle_in_if    req_tap,
    cle_out_if   rsp_tap,
    output int   fail_count,
    output int   outstanding
);

    // shadow of the line store and its three ring positions
    char_t   line_buf [BUF_DEPTH];
    int      rd_pos;
    int      cm_pos;
    int      ed_pos;
    result_t console_replies [$];

    function automatic int span(input int later, input int earlier);
        return (later + POS_MOD - earlier) % POS_MOD;
    endfunction

    // one keystroke or one read, applied to the shadow state
    task automatic edit_line(input logic op, input char_t ch, input logic started,
                             output result_t r);
        int    typed;
        char_t c;
        r = '0;
        r.echo_kind   = ECHO_NONE;
        r.read_status = RD_NONE;
        if (op == OP_RX)
        begin
            typed = span(ed_pos, cm_pos);
            if (ch == KEY_KILL)
            begin
                if (typed != 0)
                begin
                    ed_pos        = cm_pos;
                    r.echo_kind   = ECHO_ERASE;
                    r.erase_count = (typed > 255) ? ERASE_MAX : char_t'(typed);
                end
            end
            else if (ch == KEY_BS || ch == KEY_DEL)
            begin
                if (typed != 0)
                begin
                    ed_pos        = (ed_pos + POS_MOD - 1) % POS_MOD;
                    r.echo_kind   = ECHO_ERASE;
                    r.erase_count = 8'd1;
                end
            end
            else if (ch != KEY_NUL && span(ed_pos, rd_pos) < BUF_DEPTH)
            begin
                c = (ch == KEY_CR) ? KEY_LF : ch;
                r.echo_kind = ECHO_CHAR;
                r.echo_char = c;
                line_buf[ed_pos % BUF_DEPTH] = c;
                ed_pos = (ed_pos + 1) % POS_MOD;
                if (c == KEY_LF || c == KEY_EOF || span(ed_pos, rd_pos) == BUF_DEPTH)
                begin
                    cm_pos       = ed_pos;
                    r.line_ready = 1'b1;
                end
            end
        end
        else if (rd_pos == cm_pos)
        begin
            r.read_status = RD_EMPTY;
        end
        else
        begin
            c = line_buf[rd_pos % BUF_DEPTH];
            if (c == KEY_EOF && started)
            begin
                // eof stays so the next request ends empty
                r.read_status = RD_EOF_KEPT;
            end
            else
            begin
                rd_pos = (rd_pos + 1) % POS_MOD;
                if (c == KEY_EOF)
                begin
                    r.read_status = RD_EOF_TAKEN;
                end
                else
                begin
                    r.read_status = RD_BYTE;
                    r.read_char   = c;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            rd_pos = 0;
            cm_pos = 0;
            ed_pos = 0;
            console_replies.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp_tap.valid && rsp_tap.ready)
            begin
                got.echo_kind   = echo_kind_t'(rsp_tap.echo_kind);
                got.echo_char   = rsp_tap.echo_char;
                got.erase_count = rsp_tap.erase_count;
                got.line_ready  = rsp_tap.line_ready;
                got.read_status = read_status_t'(rsp_tap.read_status);
                got.read_char   = rsp_tap.read_char;
                if (console_replies.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected no beat, got", $time,
                             " kind=%0d echo=%h erase=%0d rdy=%b st=%0d rd=%h",
                             got.echo_kind, got.echo_char, got.erase_count,
                             got.line_ready, got.read_status, got.read_char);
                end
                else
                begin
                    want = console_replies.pop_front();
                    if (got.echo_kind !== want.echo_kind ||
                        got.echo_char !== want.echo_char ||
                        got.erase_count !== want.erase_count ||
                        got.line_ready !== want.line_ready ||
                        got.read_status !== want.read_status ||
                        got.read_char !== want.read_char)
                    begin
                        fail_count++;
                        $display("%0t: expected", $time,
                                 " kind=%0d echo=%h erase=%0d rdy=%b st=%0d rd=%h,",
                                 want.echo_kind, want.echo_char, want.erase_count,
                                 want.line_ready, want.read_status, want.read_char,
                                 " got kind=%0d echo=%h erase=%0d rdy=%b st=%0d rd=%h",
                                 got.echo_kind, got.echo_char, got.erase_count,
                                 got.line_ready, got.read_status, got.read_char);
                    end
                end
            end
            if (req_tap.valid && req_tap.ready)
            begin
                edit_line(req_tap.operation, req_tap.rx_char, req_tap.read_started, want);
                console_replies.push_back(want);
            end
        end
        outstanding = console_replies.size();
    end

endmodule

// ===== tb/sv/console_line_editor_top_tb.sv =====
module console_line_editor_top_tb;
    import cle_pkg::*;

    // generous cycle budget for ~1600 beats at worst gap plus worst stall
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_BEATS = 1400;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   beats_sent;
    int   unsigned cycles;

    // when set, the matching side runs without idle cycles
    bit   steady_tx;
    bit   steady_rx;

    cle_in_if  req_ch ();
    cle_out_if rsp_ch ();

    console_line_editor_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cle_line_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_tap     (req_ch),
        .rsp_tap     (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cycles <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (cycles == CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic int pick_gap(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 12));
    endfunction

    // one req beat: optional idle gap, then hold valid until taken
    // every change of valid happens at a falling edge, at most once per edge
    task automatic put_beat(input logic op, input char_t ch, input logic started);
        int gap;
        gap = pick_gap(steady_tx);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.rx_char      <= ch;
        req_ch.read_started <= started;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        beats_sent++;
    endtask

    // read_started does nothing for received bytes, so it is left random
    task automatic type_key(input char_t ch);
        put_beat(OP_RX, ch, 1'($urandom_range(0, 1)));
    endtask

    // rx_char does nothing for reads, so it is left random
    task automatic read_byte(input logic started);
        put_beat(OP_READ, char_t'($urandom_range(0, 255)), started);
    endtask

    // a reader request: the first beat starts it, later beats continue it
    task automatic read_request(input int n);
        for (int j = 0; j < n; j++)
            read_byte(j != 0);
    endtask

    // a typed line of printable text with occasional corrections, then, if
    // terminate is set, a line end of some kind; long unterminated lines can fill the store
    task automatic type_line(input int len, input bit terminate);
        int pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                type_key(KEY_BS);
            else if (pick < 8)
                type_key(KEY_DEL);
            else if (pick < 10)
                type_key(KEY_KILL);
            else
                type_key(char_t'($urandom_range(8'h20, 8'h7e)));
        end
        if (terminate)
        begin
            pick = $urandom_range(0, 2);
            type_key(pick == 0 ? KEY_CR : (pick == 1 ? KEY_LF : KEY_EOF));
        end
    endtask

    // stop offering beats until every result has come back
    task automatic drain_pause();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // result side: random stall per beat, ready only moves at falling edges
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap(steady_rx);
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
        end
    end

    initial
    begin
        int pick;
        beats_sent = 0;
        steady_tx  = 1'b0;
        steady_rx  = 1'b0;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= OP_RX;
        req_ch.rx_char      <= KEY_NUL;
        req_ch.read_started <= 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty store cases
        read_byte(1'b0);            // nothing committed
        type_key(KEY_BS);           // nothing to erase
        type_key(KEY_KILL);         // nothing to erase
        type_key(KEY_NUL);          // zero byte ignored

        // single erases, both keys
        type_key(8'h61);
        type_key(8'hff);
        type_key(KEY_BS);
        type_key(KEY_DEL);

        // line kill over two bytes
        type_key(8'h78);
        type_key(8'h79);
        type_key(KEY_KILL);

        // field extremes, cr turned into lf, bare lf line, then eof
        type_key(8'h01);
        type_key(8'h80);
        type_key(8'h40);
        type_key(KEY_CR);
        type_key(KEY_LF);
        type_key(KEY_EOF);

        // reader: bytes, eof seen mid request is kept, then taken first
        read_byte(1'b0);
        read_byte(1'b1);
        read_byte(1'b1);
        read_byte(1'b1);
        read_byte(1'b1);
        read_byte(1'b1);
        read_byte(1'b0);
        read_byte(1'b0);

        // hold off once until every result is back
        drain_pause();

        // random: mostly whole lines followed by reader requests, some
        // stray reads and raw bytes; quiet stretches switch on and off
        while (beats_sent < RANDOM_BEATS + 25)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                steady_tx = ($urandom_range(0, 2) == 0);
                steady_rx = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 59) == 0)
                drain_pause();
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                if ($urandom_range(0, 14) == 0)
                    type_line($urandom_range(120, 140), 1'($urandom_range(0, 1)));
                else
                    type_line($urandom_range(0, 20), 1'b1);
                if ($urandom_range(0, 4) != 0)
                    read_request($urandom_range(1, 24));
            end
            else if (pick < 75)
            begin
                read_request($urandom_range(1, 8));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 2) == 0)
                        read_byte(1'($urandom_range(0, 1)));
                    else
                        type_key(char_t'($urandom_range(0, 255)));
                end
            end
        end

        // let the last results arrive, then print the summary
        drain_pause();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cle_pkg.sv
rtl/cle_in_if.sv
rtl/cle_out_if.sv
rtl/cle_ram.sv
rtl/cle_ctrl.sv
rtl/console_line_editor_top.sv
rtl/cle_checker.sv
tb/sv/cle_line_checker.sv
tb/sv/console_line_editor_top_tb.sv
